@@ hw/rtl/sswc_pkg.sv @@
// ============================================================================
// sswc_pkg
// Shared types, command codes and constants of the smooth scroll window
// controller.
// ============================================================================
package sswc_pkg;

    // Event codes carried on the input channel's tuser
    localparam logic [2:0] CMD_RESET_VIEW = 3'd0;
    localparam logic [2:0] CMD_STEP       = 3'd1;
    localparam logic [2:0] CMD_DELTA      = 3'd2;
    localparam logic [2:0] CMD_TICK       = 3'd3;
    localparam logic [2:0] CMD_COMMIT     = 3'd4;
    localparam logic [2:0] CMD_SET_FORCE  = 3'd5;

    // Configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_CONTENT_PRESENT = 2'd0;
    localparam logic [1:0] REG_VIEW_LINES      = 2'd1;
    localparam logic [1:0] REG_CONTENT_LINES   = 2'd2;

    // Line constants, 17-bit signed so that 16-bit sums never overflow
    localparam logic signed [16:0] BASE_LINES  = 17'sd174;
    localparam logic signed [16:0] STEP_LINES  = 17'sd4;
    localparam logic signed [16:0] MAX_DELTA   = 17'sd64;
    localparam logic signed [16:0] UPLOAD_STEP = 17'sd32;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic        content_present;
        logic [9:0]  view_lines;
        logic [14:0] content_lines;
    } t_cfg;

    typedef struct packed {
        logic [15:0] vis_start;
        logic [15:0] vis_end;
        logic [15:0] prev_start;
        logic [15:0] prev_end;
        logic [15:0] goal_start;
        logic [15:0] cursor;
        logic        force_flag;
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               step_up;
        logic               step_down;
        logic signed [15:0] scroll_delta;
    } t_item;

    typedef struct packed {
        logic               can_scroll;
        logic signed [15:0] cursor_line;
        logic signed [15:0] window_bottom;
        logic signed [15:0] window_top;
        logic               upload_due;
        logic               changed;
    } t_result;

endpackage

@@ hw/rtl/sswc_step.sv @@
// ============================================================================
// sswc_step
// Next-state and result logic for one scroll event: extent, step target,
// clamped delta against the committed range, and upload cursor tracking.
// ============================================================================
module sswc_step (
    input  sswc_pkg::t_cfg    i_cfg,
    input  sswc_pkg::t_state  i_state,
    input  sswc_pkg::t_item   i_item,
    output sswc_pkg::t_state  o_state,
    output sswc_pkg::t_result o_res
);
    import sswc_pkg::*;

    logic [14:0]        h_eff;
    logic [16:0]        ext_sum;
    logic signed [15:0] ext;
    logic signed [16:0] ext_x;
    logic signed [16:0] vh_x;
    logic               ext_gt_vh;
    logic               active;
    logic               delta_ok;

    logic signed [15:0] delta;
    logic signed [16:0] delta_x;
    logic signed [16:0] a_neg;
    logic signed [16:0] a_pos;
    logic signed [16:0] s_sum;
    logic signed [16:0] e_sum;
    logic [15:0]        s_cl;
    logic [15:0]        e_cl;
    logic [15:0]        vs_d;
    logic [15:0]        ve_d;
    logic               moved;

    logic signed [16:0] t_up;
    logic signed [16:0] e_dn;
    logic [15:0]        up_goal;
    logic [15:0]        dn_end;
    logic [15:0]        step_goal;

    logic signed [16:0] cur_d;
    logic               far;

    // Scroll extent: viewport plus content overhang beyond the base lines
    always_comb begin
        h_eff     = (17'($unsigned(i_cfg.content_lines)) < 17'($unsigned(BASE_LINES)))
                  ? 15'(BASE_LINES) : i_cfg.content_lines;
        ext_sum   = 17'(i_cfg.view_lines) + 17'(h_eff) - 17'($unsigned(BASE_LINES));
        ext       = i_cfg.content_present ? $signed(ext_sum[15:0]) : 16'sd0;
        ext_x     = 17'(ext);
        vh_x      = $signed({7'd0, i_cfg.view_lines});
        ext_gt_vh = ext_x > vh_x;
        active    = i_cfg.content_present
                  && ($signed(i_state.prev_start) < $signed(i_state.prev_end));
        delta_ok  = active && ext_gt_vh;
    end

    // Clamped delta measured from the committed range
    always_comb begin
        delta   = (i_item.cmd == CMD_TICK)
                ? $signed(i_state.goal_start - i_state.vis_start)
                : i_item.scroll_delta;
        delta_x = 17'(delta);
        a_neg   = (delta_x < -MAX_DELTA) ? -MAX_DELTA : delta_x;
        a_pos   = (delta_x > MAX_DELTA) ? MAX_DELTA : delta_x;
        s_sum   = 17'($signed(i_state.prev_start)) + a_neg;
        e_sum   = 17'($signed(i_state.prev_end)) + a_pos;
        s_cl    = (s_sum <= 17'sd0) ? 16'd0 : s_sum[15:0];
        e_cl    = (e_sum >= ext_x) ? ext : e_sum[15:0];
        vs_d    = i_state.vis_start;
        ve_d    = i_state.vis_end;
        moved   = 1'b0;
        if (delta_ok && delta[15]) begin
            vs_d = s_cl;
            if (s_cl != i_state.prev_start) begin
                moved = 1'b1;
                ve_d  = s_cl + 16'(i_cfg.view_lines);
            end
        end else if (delta_ok && (delta != 16'sd0)) begin
            ve_d = e_cl;
            if (e_cl != i_state.prev_end) begin
                moved = 1'b1;
                vs_d  = e_cl - 16'(i_cfg.view_lines);
            end
        end
    end

    // Step target: four lines up or down, clamped to the extent
    always_comb begin
        t_up    = 17'($signed(i_state.vis_start)) - STEP_LINES;
        e_dn    = 17'($signed(i_state.vis_end)) + STEP_LINES;
        up_goal = t_up[16] ? 16'd0 : t_up[15:0];
        dn_end  = (e_dn >= ext_x) ? ext : e_dn[15:0];
        step_goal = i_state.goal_start;
        if (delta_ok && i_item.step_up) begin
            step_goal = up_goal;
        end else if (delta_ok && i_item.step_down) begin
            step_goal = dn_end - 16'(i_cfg.view_lines);
        end
    end

    // Upload cursor distance from the new visible start
    always_comb begin
        cur_d = 17'($signed(vs_d)) - 17'($signed(i_state.cursor));
        far   = (cur_d >= UPLOAD_STEP) || (cur_d <= -UPLOAD_STEP);
    end

    // Apply the event
    always_comb begin
        o_state               = i_state;
        o_res.changed         = 1'b0;
        o_res.upload_due      = 1'b0;
        case (i_item.cmd)
            CMD_RESET_VIEW: begin
                o_state.prev_start = 16'd0;
                o_state.prev_end   = 16'd0;
                o_state.vis_start  = 16'd0;
                o_state.vis_end    = 16'(i_cfg.view_lines);
                o_state.goal_start = 16'd0;
            end
            CMD_STEP: begin
                o_state.goal_start = step_goal;
                o_res.changed      = i_state.vis_start != step_goal;
            end
            CMD_DELTA: begin
                o_state.vis_start = vs_d;
                o_state.vis_end   = ve_d;
                o_res.changed     = moved;
            end
            CMD_TICK: begin
                o_state.vis_start = vs_d;
                o_state.vis_end   = ve_d;
                o_res.changed     = moved;
                if (moved && i_state.force_flag) begin
                    o_state.force_flag    = 1'b0;
                    o_state.cursor        = vs_d;
                    o_res.upload_due      = 1'b1;
                end else if (moved && far) begin
                    o_state.cursor        = cur_d[16]
                                          ? i_state.cursor - 16'(UPLOAD_STEP)
                                          : i_state.cursor + 16'(UPLOAD_STEP);
                    o_res.upload_due      = 1'b1;
                end
            end
            CMD_COMMIT: begin
                o_state.prev_start = i_state.vis_start;
                o_state.prev_end   = i_state.vis_end;
            end
            CMD_SET_FORCE: begin
                o_state.force_flag = 1'b1;
            end
            default: begin
            end
        endcase
        o_res.window_top    = $signed(o_state.vis_start);
        o_res.window_bottom = $signed(o_state.vis_end);
        o_res.cursor_line   = $signed(o_state.cursor);
        o_res.can_scroll    = ext_gt_vh;
    end

endmodule

@@ hw/rtl/smooth_scroll_window_controller.sv @@
// ============================================================================
// smooth_scroll_window_controller
// Vertical scroll window with visible, committed and target positions and an
// upload cursor; one result per event.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  s_axis    in         tvalid/tready              tuser: cmd; tdata: step, delta
//  m_axis    out        tvalid/tready              tdata: result fields
//  apb       in/out     psel/penable/pwrite/pready pwdata/prdata, 3 registers
//
//  One event per cycle sustained while the output is not stalled; a request
//  passes the input register, then the result register fed by the step logic.
//  The step logic updates the window state as a request moves into the
//  result register, so back-to-back events see the previous event's state.
//  A stalled result holds the result register; the input register still
//  takes one more request, then tready falls.
//  Synchronous active-low reset clears the window state, the force flag,
//  the configuration registers and both valid flags.
//
module smooth_scroll_window_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] step_up, [1] step_down, [17:2] scroll_delta, [23:18] zero
    input  logic [sswc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]  i_s_axis_tuser,
    // stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] changed, [1] upload_due, [17:2] window_top,
    // [33:18] window_bottom, [49:34] cursor_line, [50] can_scroll, [55:51] zero
    output logic [sswc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import sswc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    advance;
    logic    cfg_wr;

    // Configuration write and read
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                REG_CONTENT_PRESENT: r_cfg.content_present <= i_pwdata[0];
                REG_VIEW_LINES:      r_cfg.view_lines      <= i_pwdata[9:0];
                REG_CONTENT_LINES:   r_cfg.content_lines   <= i_pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_CONTENT_PRESENT: o_prdata = {31'd0, r_cfg.content_present};
            REG_VIEW_LINES:      o_prdata = {22'd0, r_cfg.view_lines};
            REG_CONTENT_LINES:   o_prdata = {17'd0, r_cfg.content_lines};
            default:             o_prdata = 32'd0;
        endcase
    end

    // Advance when a request waits and the result register is free
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.cmd          <= i_s_axis_tuser;
            r_in.step_up      <= i_s_axis_tdata[0];
            r_in.step_down    <= i_s_axis_tdata[1];
            r_in.scroll_delta <= $signed(i_s_axis_tdata[17:2]);
        end
    end

    sswc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Update the window state as the request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

    // Checks
    a_force_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.cmd == CMD_SET_FORCE) |=> r_state.force_flag)
        else $error("set force did not raise the force flag");

    a_upload_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.upload_due |-> r_out.changed)
        else $error("upload reported without window movement");

    a_upload_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.cmd != CMD_TICK) |=> !r_out.upload_due)
        else $error("upload reported for an event other than tick");

endmodule
